// ===== sv/tgpe_pkg.sv =====
// ----------------------------------------------------------------------------
// tgpe_pkg
// Shared types and constants of the 5x7 text glyph pixel emitter.
// ----------------------------------------------------------------------------
package tgpe_pkg;

  // glyph geometry
  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned GLYPH_ROWS = 7;
  localparam int unsigned CELL_COUNT = GLYPH_COLS * GLYPH_ROWS;

  // character codes with special handling
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // configuration register indexes
  localparam logic [1:0] CFG_ORIGIN_X   = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y   = 2'd1;
  localparam logic [1:0] CFG_PIXEL_SIZE = 2'd2;
  localparam logic [1:0] CFG_DRAW_COLOR = 2'd3;

  // glyph cell bits, first cell (top row, left column) in the msb
  typedef logic [CELL_COUNT-1:0] glyph_t;

  // input beat
  typedef struct packed {
    logic [7:0] char_code;
    logic       restart;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [4:0]  rect_size;
    logic [31:0] rect_color;
    logic        last;
  } out_beat_t;

endpackage

// ===== sv/tgpe_glyph_rom.sv =====
// ----------------------------------------------------------------------------
// tgpe_glyph_rom
// Maps a character byte to its 5x7 cell bitmap; lower case folds to upper
// case and any byte without a glyph gets the default glyph.
// ----------------------------------------------------------------------------
module tgpe_glyph_rom (
  input  logic [7:0]      char_code_i,
  output tgpe_pkg::glyph_t glyph_o
);
  import tgpe_pkg::*;

  localparam int unsigned SYMBOL_COUNT = 52;
  localparam int unsigned IDX_W        = $clog2(SYMBOL_COUNT + 1);

  logic [IDX_W-1:0] idx;

  // character to symbol index
  always_comb begin
    idx = IDX_W'(SYMBOL_COUNT);
    if (char_code_i >= 8'h41 && char_code_i <= 8'h5A) begin
      idx = IDX_W'(char_code_i - 8'h41);
    end else if (char_code_i >= 8'h61 && char_code_i <= 8'h7A) begin
      idx = IDX_W'(char_code_i - 8'h61);
    end else if (char_code_i >= 8'h30 && char_code_i <= 8'h39) begin
      idx = IDX_W'(char_code_i - 8'h30) + IDX_W'(26);
    end else begin
      unique case (char_code_i)
        8'h2E:   idx = IDX_W'(36); // period
        8'h2C:   idx = IDX_W'(37); // comma
        8'h3A:   idx = IDX_W'(38); // colon
        8'h2D:   idx = IDX_W'(39); // minus
        8'h2B:   idx = IDX_W'(40); // plus
        8'h2F:   idx = IDX_W'(41); // slash
        8'h28:   idx = IDX_W'(42); // open paren
        8'h29:   idx = IDX_W'(43); // close paren
        8'h5B:   idx = IDX_W'(44); // open bracket
        8'h5D:   idx = IDX_W'(45); // close bracket
        8'h3D:   idx = IDX_W'(46); // equals
        8'h5F:   idx = IDX_W'(47); // underscore
        8'h25:   idx = IDX_W'(48); // percent
        8'h21:   idx = IDX_W'(49); // exclamation
        8'h3F:   idx = IDX_W'(50); // question
        8'h20:   idx = IDX_W'(51); // space
        default: idx = IDX_W'(SYMBOL_COUNT);
      endcase
    end
  end

  // glyph bitmap table
  always_comb begin
    unique case (idx)
      6'd0:    glyph_o = 35'b01110100011000111111100011000110001;
      6'd1:    glyph_o = 35'b11110100011000111110100011000111110;
      6'd2:    glyph_o = 35'b01111100001000010000100001000001111;
      6'd3:    glyph_o = 35'b11110100011000110001100011000111110;
      6'd4:    glyph_o = 35'b11111100001000011110100001000011111;
      6'd5:    glyph_o = 35'b11111100001000011110100001000010000;
      6'd6:    glyph_o = 35'b01111100001000010011100011000101111;
      6'd7:    glyph_o = 35'b10001100011000111111100011000110001;
      6'd8:    glyph_o = 35'b11111001000010000100001000010011111;
      6'd9:    glyph_o = 35'b00111000100001000010100101001001100;
      6'd10:   glyph_o = 35'b10001100101010011000101001001010001;
      6'd11:   glyph_o = 35'b10000100001000010000100001000011111;
      6'd12:   glyph_o = 35'b10001110111010110101100011000110001;
      6'd13:   glyph_o = 35'b10001110011010110011100011000110001;
      6'd14:   glyph_o = 35'b01110100011000110001100011000101110;
      6'd15:   glyph_o = 35'b11110100011000111110100001000010000;
      6'd16:   glyph_o = 35'b01110100011000110001101011001001101;
      6'd17:   glyph_o = 35'b11110100011000111110101001001010001;
      6'd18:   glyph_o = 35'b01111100001000001110000010000111110;
      6'd19:   glyph_o = 35'b11111001000010000100001000010000100;
      6'd20:   glyph_o = 35'b10001100011000110001100011000101110;
      6'd21:   glyph_o = 35'b10001100011000110001100010101000100;
      6'd22:   glyph_o = 35'b10001100011000110101101011010101010;
      6'd23:   glyph_o = 35'b10001100010101000100010101000110001;
      6'd24:   glyph_o = 35'b10001100010101000100001000010000100;
      6'd25:   glyph_o = 35'b11111000010001000100010001000011111;
      6'd26:   glyph_o = 35'b01110100011001110101110011000101110;
      6'd27:   glyph_o = 35'b00100011000010000100001000010001110;
      6'd28:   glyph_o = 35'b01110100010000100010001000100011111;
      6'd29:   glyph_o = 35'b11110000010000101110000010000111110;
      6'd30:   glyph_o = 35'b00010001100101010010111110001000010;
      6'd31:   glyph_o = 35'b11111100001000011110000010000111110;
      6'd32:   glyph_o = 35'b01110100001000011110100011000101110;
      6'd33:   glyph_o = 35'b11111000010001000100010000100001000;
      6'd34:   glyph_o = 35'b01110100011000101110100011000101110;
      6'd35:   glyph_o = 35'b01110100011000101111000010000101110;
      6'd36:   glyph_o = 35'b00000000000000000000000000110001100;
      6'd37:   glyph_o = 35'b00000000000000000000011000010001000;
      6'd38:   glyph_o = 35'b00000011000110000000011000110000000;
      6'd39:   glyph_o = 35'b00000000000000011111000000000000000;
      6'd40:   glyph_o = 35'b00000001000010011111001000010000000;
      6'd41:   glyph_o = 35'b00001000100001000100010000100010000;
      6'd42:   glyph_o = 35'b00010001000100001000010000010000010;
      6'd43:   glyph_o = 35'b01000001000001000010000100010001000;
      6'd44:   glyph_o = 35'b01110010000100001000010000100001110;
      6'd45:   glyph_o = 35'b01110000100001000010000100001001110;
      6'd46:   glyph_o = 35'b00000111110000011111000000000000000;
      6'd47:   glyph_o = 35'b00000000000000000000000000000011111;
      6'd48:   glyph_o = 35'b11001110100001000100010000101110011;
      6'd49:   glyph_o = 35'b00100001000010000100001000000000100;
      6'd50:   glyph_o = 35'b01110100010000100010001000000000100;
      6'd51:   glyph_o = 35'b00000000000000000000000000000000000;
      // default glyph, tail padded with unlit cells
      default: glyph_o = 35'b11111100010001000100000000010000000;
    endcase
  end

endmodule

// ===== sv/text_glyph_pixel_emitter_core.sv =====
// ----------------------------------------------------------------------------
// text_glyph_pixel_emitter_core
// Text cursor and 5x7 glyph scanner: one square per lit cell of each glyph.
//
//   channel  direction  handshake              beat
//   in       input      in_valid_i/in_ready_o  in_beat_t   (char_code, restart)
//   out      output     out_valid_o/out_ready_i out_beat_t (rect_x .. last)
//   cfg      input      cfg_we_i               cfg_index_i, cfg_data_i
//
// A character is accepted, then scanned at one cell per cycle, barring output
// stalls, up to its last lit cell (at most 35, one cell for a blank glyph), then
// the cursor advances, all through one shared 17-bit adder that steps by pixel_size.
// A newline is accepted, then moves the cursor to the origin column and down a line.
// in_ready_o is high only while the sequencer is idle.
// Reset puts the cursor and origin at 0, pixel_size at 1, color all ones.
// A lit cell waits while the output register holds an untaken beat.
// ----------------------------------------------------------------------------
module text_glyph_pixel_emitter_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tgpe_pkg::in_beat_t   in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tgpe_pkg::out_beat_t  out_beat_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import tgpe_pkg::*;

  localparam int unsigned COL_W  = $clog2(GLYPH_COLS);
  localparam int unsigned STEP_W = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ADV,
    ST_NL
  } state_e;

  // configuration registers
  logic [15:0] origin_x_q, origin_y_q;
  logic [4:0]  pixel_size_q;
  logic [31:0] draw_color_q;

  // sequencer and datapath registers
  state_e      state_q;
  logic [15:0] cursor_x_q, cursor_y_q;
  logic [16:0] x_acc_q, y_acc_q;
  glyph_t      glyph_q;
  logic [COL_W-1:0]  col_q;
  logic [STEP_W-1:0] step_q;
  logic [4:0]  ps_q;
  logic [31:0] color_q;
  logic        out_valid_q;
  out_beat_t   out_q;

  // combinational signals
  glyph_t      rom_glyph;
  logic [4:0]  eff_size;
  logic [15:0] cx, cy;
  logic        add_to_y;
  logic [16:0] sum;
  logic        rest_empty;
  logic        advance;
  logic        emit;
  logic        in_fire;

  function automatic logic [15:0] sat16(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

  tgpe_glyph_rom u_rom (
    .char_code_i (in_beat_i.char_code),
    .glyph_o     (rom_glyph)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      pixel_size_q <= 5'd1;
      draw_color_q <= 32'hFFFF_FFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ORIGIN_X:   origin_x_q   <= cfg_data_i[15:0];
        CFG_ORIGIN_Y:   origin_y_q   <= cfg_data_i[15:0];
        CFG_PIXEL_SIZE: pixel_size_q <= cfg_data_i[4:0];
        CFG_DRAW_COLOR: draw_color_q <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // clamp pixel size to 1..16
  always_comb begin
    if (pixel_size_q == 5'd0) begin
      eff_size = 5'd1;
    end else if (pixel_size_q > 5'd16) begin
      eff_size = 5'd16;
    end else begin
      eff_size = pixel_size_q;
    end
  end

  // cursor at accept, after an optional restart
  assign cx = in_beat_i.restart ? origin_x_q : cursor_x_q;
  assign cy = in_beat_i.restart ? origin_y_q : cursor_y_q;

  // shared adder: steps x along a row and in the cursor advance, y down rows and newlines
  assign add_to_y = (state_q == ST_NL) ||
                    ((state_q == ST_SCAN) && (col_q == COL_W'(GLYPH_COLS - 1)));
  assign sum      = (add_to_y ? y_acc_q : x_acc_q) + 17'(ps_q);

  // scan control
  assign rest_empty = (glyph_q[CELL_COUNT-2:0] == '0);
  assign advance    = !(glyph_q[CELL_COUNT-1] && out_valid_q && !out_ready_i);
  assign emit       = (state_q == ST_SCAN) && glyph_q[CELL_COUNT-1] && advance;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // sequencer, cursor and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_x_q  <= '0;
      cursor_y_q  <= '0;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
      glyph_q     <= '0;
      col_q       <= '0;
      step_q      <= '0;
      ps_q        <= 5'd1;
      color_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // output beat register
      if (emit) begin
        out_valid_q      <= 1'b1;
        out_q.rect_x     <= sat16(x_acc_q);
        out_q.rect_y     <= sat16(y_acc_q);
        out_q.rect_size  <= ps_q;
        out_q.rect_color <= color_q;
        out_q.last       <= rest_empty;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            ps_q    <= eff_size;
            color_q <= draw_color_q;
            if (in_beat_i.char_code == NEWLINE_CODE) begin
              cursor_x_q <= origin_x_q;
              y_acc_q    <= {1'b0, cy};
              step_q     <= STEP_W'(GLYPH_ROWS + 1);
              state_q    <= ST_NL;
            end else begin
              cursor_x_q <= cx;
              cursor_y_q <= cy;
              x_acc_q    <= {1'b0, cx};
              y_acc_q    <= {1'b0, cy};
              glyph_q    <= rom_glyph;
              col_q      <= '0;
              state_q    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (advance) begin
            glyph_q <= glyph_q << 1;
            if (rest_empty) begin
              x_acc_q <= {1'b0, cursor_x_q};
              step_q  <= STEP_W'(GLYPH_COLS);
              state_q <= ST_ADV;
            end else if (col_q == COL_W'(GLYPH_COLS - 1)) begin
              col_q   <= '0;
              x_acc_q <= {1'b0, cursor_x_q};
              y_acc_q <= sum;
            end else begin
              col_q   <= col_q + COL_W'(1);
              x_acc_q <= sum;
            end
          end
        end
        ST_ADV: begin
          x_acc_q <= sum;
          if (step_q == '0) begin
            cursor_x_q <= sat16(sum);
            state_q    <= ST_IDLE;
          end else begin
            step_q <= step_q - STEP_W'(1);
          end
        end
        ST_NL: begin
          y_acc_q <= sum;
          if (step_q == '0) begin
            cursor_y_q <= sat16(sum);
            state_q    <= ST_IDLE;
          end else begin
            step_q <= step_q - STEP_W'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // latched pixel size stays within 1..16
  a_ps_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ps_q != 5'd0) && (ps_q <= 5'd16))
    else $error("pixel size register out of range");

  // column counter stays inside the glyph
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= COL_W'(GLYPH_COLS - 1))
    else $error("column counter past glyph width");

  // the final square of a glyph hands over to the cursor advance
  a_last_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && rest_empty) |=> (state_q == ST_ADV))
    else $error("last square not followed by cursor advance");

  // an accepted newline starts the line step and emits nothing
  a_nl_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_beat_i.char_code == NEWLINE_CODE))
      |=> ((state_q == ST_NL) && !emit))
    else $error("newline did not enter line step");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for text_glyph_pixel_emitter_core. Character beats go in
// over valid/ready with random gaps, squares come out under random stalls.
// A scoreboard keeps its own cursor, registers and 5x7 font, works out the
// squares each accepted character should give, and checks every output beat
// field by field in order. Directed characters and register settings
// come first, then random phases with fresh register settings each.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tgpe_pkg::*;

  // symbols with a glyph, first symbol in the top byte
  localparam int unsigned SYMBOL_COUNT = 52;
  localparam logic [8*SYMBOL_COUNT-1:0] GLYPH_CHARS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,:-+/()[]=_%!? ";

  // font rows top to bottom, first cell in the msb; last entry is the default
  localparam glyph_t GLYPH_ROM [0:SYMBOL_COUNT] = '{
    35'b01110100011000111111100011000110001,
    35'b11110100011000111110100011000111110,
    35'b01111100001000010000100001000001111,
    35'b11110100011000110001100011000111110,
    35'b11111100001000011110100001000011111,
    35'b11111100001000011110100001000010000,
    35'b01111100001000010011100011000101111,
    35'b10001100011000111111100011000110001,
    35'b11111001000010000100001000010011111,
    35'b00111000100001000010100101001001100,
    35'b10001100101010011000101001001010001,
    35'b10000100001000010000100001000011111,
    35'b10001110111010110101100011000110001,
    35'b10001110011010110011100011000110001,
    35'b01110100011000110001100011000101110,
    35'b11110100011000111110100001000010000,
    35'b01110100011000110001101011001001101,
    35'b11110100011000111110101001001010001,
    35'b01111100001000001110000010000111110,
    35'b11111001000010000100001000010000100,
    35'b10001100011000110001100011000101110,
    35'b10001100011000110001100010101000100,
    35'b10001100011000110101101011010101010,
    35'b10001100010101000100010101000110001,
    35'b10001100010101000100001000010000100,
    35'b11111000010001000100010001000011111,
    35'b01110100011001110101110011000101110,
    35'b00100011000010000100001000010001110,
    35'b01110100010000100010001000100011111,
    35'b11110000010000101110000010000111110,
    35'b00010001100101010010111110001000010,
    35'b11111100001000011110000010000111110,
    35'b01110100001000011110100011000101110,
    35'b11111000010001000100010000100001000,
    35'b01110100011000101110100011000101110,
    35'b01110100011000101111000010000101110,
    35'b00000000000000000000000000110001100,
    35'b00000000000000000000011000010001000,
    35'b00000011000110000000011000110000000,
    35'b00000000000000011111000000000000000,
    35'b00000001000010011111001000010000000,
    35'b00001000100001000100010000100010000,
    35'b00010001000100001000010000010000010,
    35'b01000001000001000010000100010001000,
    35'b01110010000100001000010000100001110,
    35'b01110000100001000010000100001001110,
    35'b00000111110000011111000000000000000,
    35'b00000000000000000000000000000011111,
    35'b11001110100001000100010000101110011,
    35'b00100001000010000100001000000000100,
    35'b01110100010000100010001000000000100,
    35'b00000000000000000000000000000000000,
    35'b11111100010001000100000000010000000
  };

  localparam int unsigned DRAIN_CYCLES = 50;

  // squares due from each accepted character, checked in order
  class square_scoreboard;
    logic [15:0] origin_x, origin_y, cursor_x, cursor_y;
    logic [4:0]  pixel_size;
    logic [31:0] draw_color;
    out_beat_t   squares_due[$];
    int unsigned fail_count;

    function new();
      origin_x   = '0;
      origin_y   = '0;
      cursor_x   = '0;
      cursor_y   = '0;
      pixel_size = 5'd1;
      draw_color = '1;
      fail_count = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_ORIGIN_X:   origin_x   = data[15:0];
        CFG_ORIGIN_Y:   origin_y   = data[15:0];
        CFG_PIXEL_SIZE: pixel_size = data[4:0];
        CFG_DRAW_COLOR: draw_color = data;
        default: ;
      endcase
    endfunction

    function logic [15:0] sat_add(logic [15:0] a, int unsigned b);
      int unsigned sum;
      sum = int'(a) + b;
      return (sum > 65535) ? 16'hFFFF : sum[15:0];
    endfunction

    function int unsigned glyph_of(logic [7:0] code);
      logic [7:0] up;
      up = (code >= "a" && code <= "z") ? code - 8'd32 : code;
      for (int unsigned i = 0; i < SYMBOL_COUNT; i++) begin
        if (GLYPH_CHARS[8*(SYMBOL_COUNT-1-i) +: 8] == up) return i;
      end
      return SYMBOL_COUNT;
    endfunction

    // accepted character: cursor update and the squares it lights
    function void take_char(in_beat_t beat);
      int unsigned ps;
      glyph_t      cells;
      out_beat_t   sq;
      out_beat_t   lit[$];
      ps = (pixel_size == 0) ? 1 : (pixel_size > 16) ? 16 : pixel_size;
      if (beat.restart) begin
        cursor_x = origin_x;
        cursor_y = origin_y;
      end
      if (beat.char_code == NEWLINE_CODE) begin
        cursor_x = origin_x;
        cursor_y = sat_add(cursor_y, (GLYPH_ROWS + 2) * ps);
        return;
      end
      cells = GLYPH_ROM[glyph_of(beat.char_code)];
      for (int unsigned row = 0; row < GLYPH_ROWS; row++) begin
        for (int unsigned col = 0; col < GLYPH_COLS; col++) begin
          if (cells[CELL_COUNT-1-(row*GLYPH_COLS+col)]) begin
            sq.rect_x     = sat_add(cursor_x, col * ps);
            sq.rect_y     = sat_add(cursor_y, row * ps);
            sq.rect_size  = ps[4:0];
            sq.rect_color = draw_color;
            sq.last       = 1'b0;
            lit.push_back(sq);
          end
        end
      end
      if (lit.size() > 0) lit[lit.size()-1].last = 1'b1;
      foreach (lit[i]) squares_due.push_back(lit[i]);
      cursor_x = sat_add(cursor_x, (GLYPH_COLS + 1) * ps);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_square(out_beat_t got);
      out_beat_t want;
      if (squares_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected square, expected none, actual %h", $time, got);
        return;
      end
      want = squares_due.pop_front();
      if (got.rect_x !== want.rect_x)
        report("rect_x", 32'(want.rect_x), 32'(got.rect_x));
      if (got.rect_y !== want.rect_y)
        report("rect_y", 32'(want.rect_y), 32'(got.rect_y));
      if (got.rect_size !== want.rect_size)
        report("rect_size", 32'(want.rect_size), 32'(got.rect_size));
      if (got.rect_color !== want.rect_color)
        report("rect_color", want.rect_color, got.rect_color);
      if (got.last !== want.last)
        report("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_beat_t    in_beat_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_beat_t   out_beat_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  square_scoreboard book;
  bit               steady;

  text_glyph_pixel_emitter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #12_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned draw_wait();
    return steady ? 0 : $urandom_range(0, 11);
  endfunction

  // one character beat, held until taken
  task automatic send_char(logic [7:0] code, logic restart);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    in_beat_i.char_code <= code;
    in_beat_i.restart   <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    book.take_char('{char_code: code, restart: restart});
  endtask

  // wait out every due square and the cursor step behind it
  task automatic settle();
    in_valid_i <= 1'b0;
    while (book.squares_due.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write all four registers back to back, block idle
  task automatic program_regs(logic [31:0] ox, logic [31:0] oy, logic [31:0] ps,
                              logic [31:0] color);
    logic [31:0] vals [4];
    vals = '{ox, oy, ps, color};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= 2'(i);
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      book.set_reg(2'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // output side: random stalls, check each beat taken
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      book.check_square(out_beat_o);
    end
  end

  // stimulus
  initial begin
    logic [7:0]  code;
    logic [31:0] ox, oy, ps, color;
    int unsigned pick;
    book        = new();
    steady      = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_beat_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: letters, digits, punctuation, blank, control and high bytes
    send_char("A", 1'b1);
    send_char("z", 1'b0);
    send_char("0", 1'b0);
    send_char("9", 1'b0);
    send_char(" ", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(NEWLINE_CODE, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b0);
    send_char("%", 1'b0);
    send_char("_", 1'b0);
    send_char("?", 1'b0);
    settle();

    // origin moved but cursor stays until restart; size above range; x saturates
    program_regs(32'hABCD_FFFA, 32'h0000_0064, 32'd31, 32'h0000_0000);
    send_char("M", 1'b0);
    send_char("W", 1'b1);
    send_char(NEWLINE_CODE, 1'b0);
    send_char("#", 1'b0);
    settle();

    // size zero, y at the top of the range
    program_regs(32'd0, 32'hFFFF_FFFF, 32'd0, 32'h1234_5678);
    send_char("8", 1'b1);
    send_char(NEWLINE_CODE, 1'b0);
    send_char(".", 1'b0);
    settle();

    // largest size from the origin
    program_regs(32'd0, 32'd0, 32'd16, 32'hFFFF_FFFF);
    send_char("@", 1'b1);
    send_char("{", 1'b0);
    send_char(NEWLINE_CODE, 1'b1);
    send_char("&", 1'b0);
    settle();

    // random phases, each with its own register settings
    for (int phase = 0; phase < 8; phase++) begin
      steady = (phase % 3 == 1);
      case ($urandom_range(0, 3))
        0:       ox = 32'd0;
        1:       ox = $urandom_range(65000, 65535);
        default: ox = $urandom_range(0, 1000);
      endcase
      case ($urandom_range(0, 3))
        0:       oy = 32'hFFFF;
        1:       oy = $urandom_range(60000, 65535);
        default: oy = $urandom_range(0, 1000);
      endcase
      case ($urandom_range(0, 5))
        0:       ps = 32'd0;
        1:       ps = 32'd1;
        2:       ps = 32'd16;
        3:       ps = $urandom_range(17, 31);
        default: ps = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 3))
        0:       color = 32'h0000_0000;
        1:       color = 32'hFFFF_FFFF;
        default: color = $urandom();
      endcase
      // upper data bits of origins and size random, outside each register's width
      ox[31:16] = 16'($urandom());
      oy[31:16] = 16'($urandom());
      ps[31:5]  = 27'($urandom());
      program_regs(ox, oy, ps, color);

      for (int n = 0; n < 50; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)
          code = GLYPH_CHARS[8*$urandom_range(0, SYMBOL_COUNT-1) +: 8];
        else if (pick < 72)
          code = "a" + 8'($urandom_range(0, 25));
        else if (pick < 80)
          code = NEWLINE_CODE;
        else
          code = 8'($urandom_range(0, 255));
        send_char(code, (n == 0) || ($urandom_range(0, 15) == 0));
      end
      settle();
    end

    // final verdict
    if (book.fail_count == 0 && book.squares_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
